@@ hdl/pgs_pkg.sv @@
package pgs_pkg;

  localparam int MAX_ROWS_DEF      = 32;
  localparam int FRACTION_BITS_DEF = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;

  localparam logic [CFG_IDX_W-1:0] CFG_SYSTEM_SIZE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ITERATION_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_THRESHOLD  = 2'd2;

  // Item kinds
  localparam logic [1:0] KIND_MATRIX = 2'd0;
  localparam logic [1:0] KIND_ROW    = 2'd1;
  localparam logic [1:0] KIND_SOLVE  = 2'd2;

  localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};
  localparam logic signed [31:0] S32_MAX = {1'b0, {31{1'b1}}};
  localparam logic signed [31:0] S32_MIN = {1'b1, {31{1'b0}}};

endpackage

@@ hdl/projected_gauss_seidel_solver.sv @@
// Box-constrained projected Gauss-Seidel solver, Q16.16 by default. Load items (matrix
// entries, or a row's rhs/lower/upper/initial guess) are taken whenever the solver is
// idle. A solve item runs sweeps on one shared 33x33 multiplier and a bit-serial 64/32
// divider under a small sequencer; in_ready stays low until every result row has been
// taken. Per row a sweep reads, multiplies and accumulates each column for the dot
// product, forms the residual, divides by the diagonal (skipped on a zero diagonal),
// then updates, clamps and squares the change; each sweep ends with a convergence check,
// and a solve starts by squaring the stop threshold. Each result is read from the
// solution store and held while out_ready is low. The solution store keeps its values
// between solves, so a new solve starts from the last answer unless fresh guesses are
// loaded. Unwritten store entries read as arbitrary values.
module projected_gauss_seidel_solver #(
  parameter int MAX_ROWS      = pgs_pkg::MAX_ROWS_DEF,
  parameter int FRACTION_BITS = pgs_pkg::FRACTION_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [pgs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pgs_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_kind,
  input  logic [4:0]                    in_row,
  input  logic [4:0]                    in_column,
  input  logic signed [31:0]            in_matrix_value,
  input  logic signed [31:0]            in_rhs_value,
  input  logic signed [31:0]            in_lower_bound,
  input  logic signed [31:0]            in_upper_bound,
  input  logic signed [31:0]            in_initial_guess,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [4:0]                    out_row_index,
  output logic signed [31:0]            out_solution,
  output logic                          out_last,
  output logic [15:0]                   out_sweeps_used,
  output logic                          out_converged,
  output logic                          out_zero_diagonal
);
  import pgs_pkg::*;

  localparam int ROW_LIMIT = (MAX_ROWS < 32) ? MAX_ROWS : 32;
  localparam int RW        = $clog2(ROW_LIMIT);
  localparam int NW        = RW + 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_THR  = 4'd1;
  localparam logic [3:0] S_THR2 = 4'd2;
  localparam logic [3:0] S_RD   = 4'd3;
  localparam logic [3:0] S_MUL  = 4'd4;
  localparam logic [3:0] S_ACC  = 4'd5;
  localparam logic [3:0] S_RROW = 4'd6;
  localparam logic [3:0] S_RES  = 4'd7;
  localparam logic [3:0] S_DIV  = 4'd8;
  localparam logic [3:0] S_UPD  = 4'd9;
  localparam logic [3:0] S_SQ   = 4'd10;
  localparam logic [3:0] S_DACC = 4'd11;
  localparam logic [3:0] S_SEND = 4'd12;
  localparam logic [3:0] S_ORD  = 4'd13;
  localparam logic [3:0] S_OUT  = 4'd14;

  // Configuration registers
  logic [5:0]  size_r;
  logic [15:0] limit_r;
  logic [30:0] thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r  <= 6'd1;
      limit_r <= 16'd20;
      thr_r   <= 31'd66;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SYSTEM_SIZE:     size_r  <= cfg_wdata[5:0];
        CFG_ITERATION_LIMIT: limit_r <= cfg_wdata[15:0];
        CFG_STOP_THRESHOLD:  thr_r   <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  // Control state
  logic [3:0]    state_r, state_nxt;
  logic [RW-1:0] i_r, i_nxt, j_r, j_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic [15:0]   sweeps_r, sweeps_nxt;
  logic [5:0]    cnt_r, cnt_nxt;
  logic          have_prev_r, have_prev_nxt;
  logic          conv_r, conv_nxt;
  logic          zdiag_r, zdiag_nxt;

  // Datapath
  logic signed [63:0] acc_r, acc_nxt;
  logic [63:0]        dist_r, dist_nxt;
  logic [61:0]        thr2_r, thr2_nxt;
  logic signed [65:0] prod_r;
  logic signed [32:0] diff_r, diff_nxt;
  logic signed [31:0] xold_r, xold_nxt, lo_r, lo_nxt, hi_r, hi_nxt;
  logic [31:0]        rem_r, rem_nxt, dsr_r, dsr_nxt;
  logic [63:0]        dvd_r, dvd_nxt;
  logic               qneg_r, qneg_nxt;

  // Stores
  logic signed [31:0] coef_mem [2**(2*RW)];
  logic signed [31:0] rhs_mem  [ROW_LIMIT];
  logic signed [31:0] lo_mem   [ROW_LIMIT];
  logic signed [31:0] hi_mem   [ROW_LIMIT];
  logic signed [31:0] x_mem    [ROW_LIMIT];
  logic signed [31:0] coef_q, rhs_q, lo_q, hi_q, x_q;

  logic [2*RW-1:0] coef_ra;
  logic [RW-1:0]   x_ra;
  logic            in_take, load_ok, row_ok;
  logic            x_we;
  logic [RW-1:0]   x_wa;
  logic signed [31:0] x_wd;

  assign in_ready = (state_r == S_IDLE);
  assign in_take  = in_valid && in_ready;
  assign row_ok   = (6'(in_row) < 6'(ROW_LIMIT));
  assign load_ok  = row_ok && (6'(in_column) < 6'(ROW_LIMIT));

  assign coef_ra = (state_r == S_RD) ? {i_r, j_r} : {i_r, i_r};
  assign x_ra    = (state_r == S_RD) ? j_r : i_r;

  always_ff @(posedge clk) begin
    if (in_take && in_kind == KIND_MATRIX && load_ok) begin
      coef_mem[{in_row[RW-1:0], in_column[RW-1:0]}] <= in_matrix_value;
    end
    coef_q <= coef_mem[coef_ra];
  end

  always_ff @(posedge clk) begin
    if (in_take && in_kind == KIND_ROW && row_ok) begin
      rhs_mem[in_row[RW-1:0]] <= in_rhs_value;
      lo_mem[in_row[RW-1:0]]  <= in_lower_bound;
      hi_mem[in_row[RW-1:0]]  <= in_upper_bound;
    end
    rhs_q <= rhs_mem[i_r];
    lo_q  <= lo_mem[i_r];
    hi_q  <= hi_mem[i_r];
  end

  always_ff @(posedge clk) begin
    if (x_we) begin
      x_mem[x_wa] <= x_wd;
    end
    x_q <= x_mem[x_ra];
  end

  // Shared multiplier, registered
  logic signed [32:0] ma, mb;
  always_comb begin
    case (state_r)
      S_THR: begin
        ma = $signed({2'b00, thr_r});
        mb = $signed({2'b00, thr_r});
      end
      S_MUL: begin
        ma = 33'(coef_q);
        mb = 33'(x_q);
      end
      default: begin
        ma = diff_r;
        mb = diff_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= ma * mb;
  end

  // Combinational helpers
  logic [NW-1:0]      n_calc;
  logic signed [64:0] acc_sum, res_sum;
  logic signed [63:0] acc_sat, res, neg_acc, rhs_sc;
  logic [63:0]        res_mag;
  logic [31:0]        diag_mag;
  logic [64:0]        dist_sum;
  logic [32:0]        div_t;
  logic               div_ge;
  logic signed [31:0] q32, v_sat, v_clamp;
  logic signed [32:0] v_sum;
  logic               last_row, last_col;

  always_comb begin
    if (size_r == 6'd0) begin
      n_calc = NW'(1);
    end else if (7'(size_r) > 7'(ROW_LIMIT)) begin
      n_calc = NW'(ROW_LIMIT);
    end else begin
      n_calc = NW'(size_r);
    end

    last_col = (NW'(j_r) == n_r - NW'(1));
    last_row = (NW'(i_r) == n_r - NW'(1));

    acc_sum = {acc_r[63], acc_r} + {prod_r[63], prod_r[63:0]};
    if (acc_sum[64] != acc_sum[63]) begin
      acc_sat = acc_sum[64] ? S64_MIN : S64_MAX;
    end else begin
      acc_sat = acc_sum[63:0];
    end

    rhs_sc  = 64'(rhs_q) <<< FRACTION_BITS;
    neg_acc = (acc_r == S64_MIN) ? S64_MAX : -acc_r;
    res_sum = {rhs_sc[63], rhs_sc} + {neg_acc[63], neg_acc};
    if (res_sum[64] != res_sum[63]) begin
      res = res_sum[64] ? S64_MIN : S64_MAX;
    end else begin
      res = res_sum[63:0];
    end
    res_mag  = res[63] ? 64'(-res) : 64'(res);
    diag_mag = coef_q[31] ? 32'(-coef_q) : 32'(coef_q);

    div_t  = {rem_r, dvd_r[63]};
    div_ge = (div_t >= {1'b0, dsr_r});

    // Quotient saturated to 32 bits, then added and clamped
    if (!qneg_r) begin
      q32 = (dvd_r > 64'h7FFF_FFFF) ? S32_MAX : $signed(dvd_r[31:0]);
    end else begin
      q32 = (dvd_r > 64'h8000_0000) ? S32_MIN : $signed(-dvd_r[31:0]);
    end
    v_sum = 33'(xold_r) + 33'(q32);
    if (v_sum[32] != v_sum[31]) begin
      v_sat = v_sum[32] ? S32_MIN : S32_MAX;
    end else begin
      v_sat = v_sum[31:0];
    end
    v_clamp = v_sat;
    if (v_clamp < lo_r) v_clamp = lo_r;
    if (v_clamp > hi_r) v_clamp = hi_r;

    dist_sum = {1'b0, dist_r} + {1'b0, prod_r[63:0]};
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    n_nxt         = n_r;
    sweeps_nxt    = sweeps_r;
    cnt_nxt       = cnt_r;
    have_prev_nxt = have_prev_r;
    conv_nxt      = conv_r;
    zdiag_nxt     = zdiag_r;
    acc_nxt       = acc_r;
    dist_nxt      = dist_r;
    thr2_nxt      = thr2_r;
    diff_nxt      = diff_r;
    xold_nxt      = xold_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    rem_nxt       = rem_r;
    dvd_nxt       = dvd_r;
    dsr_nxt       = dsr_r;
    qneg_nxt      = qneg_r;
    x_we          = 1'b0;
    x_wa          = i_r;
    x_wd          = v_clamp;

    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          if (in_kind == KIND_ROW && row_ok) begin
            x_we = 1'b1;
            x_wa = in_row[RW-1:0];
            x_wd = in_initial_guess;
          end
          if (in_kind == KIND_SOLVE) begin
            n_nxt         = n_calc;
            sweeps_nxt    = 16'd0;
            have_prev_nxt = 1'b0;
            conv_nxt      = 1'b0;
            zdiag_nxt     = 1'b0;
            i_nxt         = '0;
            j_nxt         = '0;
            state_nxt     = S_THR;
          end
        end
      end
      S_THR: state_nxt = S_THR2;
      S_THR2: begin
        thr2_nxt = prod_r[61:0];
        acc_nxt  = '0;
        dist_nxt = '0;
        state_nxt = (limit_r == 16'd0) ? S_ORD : S_RD;
      end
      S_RD:  state_nxt = S_MUL;
      S_MUL: state_nxt = S_ACC;
      S_ACC: begin
        acc_nxt = acc_sat;
        if (last_col) begin
          j_nxt     = '0;
          state_nxt = S_RROW;
        end else begin
          j_nxt     = j_r + RW'(1);
          state_nxt = S_RD;
        end
      end
      S_RROW: state_nxt = S_RES;
      S_RES: begin
        xold_nxt = x_q;
        lo_nxt   = lo_q;
        hi_nxt   = hi_q;
        if (coef_q == 32'sd0) begin
          zdiag_nxt = 1'b1;
          dvd_nxt   = '0;
          qneg_nxt  = 1'b0;
          state_nxt = S_UPD;
        end else begin
          rem_nxt   = '0;
          dvd_nxt   = res_mag;
          dsr_nxt   = diag_mag;
          qneg_nxt  = res[63] ^ coef_q[31];
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        rem_nxt = div_ge ? 32'(div_t - {1'b0, dsr_r}) : div_t[31:0];
        dvd_nxt = {dvd_r[62:0], div_ge};
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd63) state_nxt = S_UPD;
      end
      S_UPD: begin
        x_we      = 1'b1;
        diff_nxt  = 33'(xold_r) - 33'(v_clamp);
        state_nxt = S_SQ;
      end
      S_SQ: state_nxt = S_DACC;
      S_DACC: begin
        dist_nxt = dist_sum[64] ? '1 : dist_sum[63:0];
        acc_nxt  = '0;
        j_nxt    = '0;
        if (last_row) begin
          state_nxt = S_SEND;
        end else begin
          i_nxt     = i_r + RW'(1);
          state_nxt = S_RD;
        end
      end
      S_SEND: begin
        sweeps_nxt = sweeps_r + 16'd1;
        i_nxt      = '0;
        dist_nxt   = '0;
        if (have_prev_r && dist_r < 64'(thr2_r)) begin
          conv_nxt  = 1'b1;
          state_nxt = S_ORD;
        end else begin
          have_prev_nxt = 1'b1;
          state_nxt = (17'(sweeps_r) + 17'd1 < 17'(limit_r)) ? S_RD : S_ORD;
        end
      end
      S_ORD: state_nxt = S_OUT;
      S_OUT: begin
        if (out_ready) begin
          if (last_row) begin
            i_nxt     = '0;
            state_nxt = S_IDLE;
          end else begin
            i_nxt     = i_r + RW'(1);
            state_nxt = S_ORD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      i_r         <= '0;
      j_r         <= '0;
      n_r         <= NW'(1);
      sweeps_r    <= '0;
      cnt_r       <= '0;
      have_prev_r <= 1'b0;
      conv_r      <= 1'b0;
      zdiag_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      n_r         <= n_nxt;
      sweeps_r    <= sweeps_nxt;
      cnt_r       <= cnt_nxt;
      have_prev_r <= have_prev_nxt;
      conv_r      <= conv_nxt;
      zdiag_r     <= zdiag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    dist_r <= dist_nxt;
    thr2_r <= thr2_nxt;
    diff_r <= diff_nxt;
    xold_r <= xold_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    rem_r  <= rem_nxt;
    dvd_r  <= dvd_nxt;
    dsr_r  <= dsr_nxt;
    qneg_r <= qneg_nxt;
  end

  // Hold each result in the read register of the solution store until taken
  assign out_valid         = (state_r == S_OUT);
  assign out_row_index     = 5'(i_r);
  assign out_solution      = x_q;
  assign out_last          = last_row;
  assign out_sweeps_used   = sweeps_r;
  assign out_converged     = conv_r;
  assign out_zero_diagonal = zdiag_r;

endmodule

@@ hdl/pgs_checker.sv @@
module pgs_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          cfg_we,
  input logic [pgs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [pgs_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [1:0]                    in_kind,
  input logic [4:0]                    in_row,
  input logic [4:0]                    in_column,
  input logic signed [31:0]            in_matrix_value,
  input logic signed [31:0]            in_rhs_value,
  input logic signed [31:0]            in_lower_bound,
  input logic signed [31:0]            in_upper_bound,
  input logic signed [31:0]            in_initial_guess,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [4:0]                    out_row_index,
  input logic signed [31:0]            out_solution,
  input logic                          out_last,
  input logic [15:0]                   out_sweeps_used,
  input logic                          out_converged,
  input logic                          out_zero_diagonal
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_solution) && $stable(out_row_index))
    else $error("stalled result changed");

  // Drop no input while results drain
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready while results pending");

  // First sweep never converges
  a_conv_sweeps: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_converged |-> out_sweeps_used >= 16'd2)
    else $error("converged before second sweep");

  // Advance row by row
  a_row_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |-> ##2
      (out_valid && out_row_index == 5'($past(out_row_index, 2) + 5'd1)))
    else $error("result rows out of order");

endmodule

bind projected_gauss_seidel_solver pgs_checker u_pgs_checker (.*);
